### design/scd_pkg.sv
package scd_pkg;

  localparam int unsigned MAX_CELLS_DEF = 65536;
  localparam int unsigned DIV_STEPS     = 80;
  localparam int unsigned BYTE_W        = 8;

  localparam logic signed [47:0] V48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] V48_MIN = 48'sh8000_0000_0000;
  localparam logic signed [63:0] V64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] V64_MIN = 64'sh8000_0000_0000_0000;

  localparam logic [3:0] REG_CELL_BYTES   = 4'd0;
  localparam logic [3:0] REG_BIG_ENDIAN   = 4'd1;
  localparam logic [3:0] REG_SIGNED_CELLS = 4'd2;
  localparam logic [3:0] REG_SCALE_MODE   = 4'd3;
  localparam logic [3:0] REG_NUM_GAIN     = 4'd4;
  localparam logic [3:0] REG_NUM_OFFSET   = 4'd5;
  localparam logic [3:0] REG_DEN_CONST    = 4'd6;
  localparam logic [3:0] REG_DEN_GAIN     = 4'd7;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_PREP, ST_DIV, ST_ACC, ST_MSTART, ST_MWAIT, ST_OUT
  } state_t;

  typedef struct packed {
    logic idle;
    logic mul_en;
    logic div_start;
    logic acc_en;
    logic mean_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic full;
    logic last;
    logic out_busy;
  } stat_t;

  typedef struct packed {
    logic [2:0]         cell_bytes;
    logic               big_endian;
    logic               signed_cells;
    logic               scale_mode;
    logic signed [31:0] num_gain;
    logic signed [31:0] num_offset;
    logic signed [31:0] den_const;
    logic signed [31:0] den_gain;
  } cfg_t;

  // Builds one cell from its bytes; the result is wide enough for any unsigned cell.
  function automatic logic signed [32:0] assemble(input logic [31:0] x, input cfg_t cfg);
    logic [31:0] v;
    logic        sb;
    logic [2:0]  n;
    n = (cfg.cell_bytes == 3'd0) ? 3'd1 : ((cfg.cell_bytes > 3'd4) ? 3'd4 : cfg.cell_bytes);
    v  = '0;
    sb = 1'b0;
    case (n)
      3'd1: begin
        v  = {24'd0, x[7:0]};
        sb = x[7];
      end
      3'd2: begin
        v  = cfg.big_endian ? {16'd0, x[7:0], x[15:8]} : {16'd0, x[15:0]};
        sb = v[15];
      end
      3'd3: begin
        v  = cfg.big_endian ? {8'd0, x[7:0], x[15:8], x[23:16]} : {8'd0, x[23:0]};
        sb = v[23];
      end
      default: begin
        v  = cfg.big_endian ? {x[7:0], x[15:8], x[23:16], x[31:24]} : x;
        sb = v[31];
      end
    endcase
    if (cfg.signed_cells && sb) begin
      case (n)
        3'd1:    v[31:8]  = '1;
        3'd2:    v[31:16] = '1;
        3'd3:    v[31:24] = '1;
        default: v = v;
      endcase
      return $signed({1'b1, v});
    end
    return $signed({1'b0, v});
  endfunction

endpackage

### design/scd_div.sv
module scd_div
  import scd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [79:0]         dividend,
  input  logic [63:0]         divisor,
  input  logic                neg,
  output logic                done,
  output logic signed [47:0]  result
);

  localparam int unsigned CW = $clog2(DIV_STEPS);

  logic [79:0]   dvd_r;
  logic [63:0]   dvs_r, rem_r;
  logic [49:0]   q_r;
  logic          sat_r, neg_r, busy_r, done_r;
  logic [CW-1:0] cnt_r;

  logic [63:0] rem_sh, rem_nxt;
  logic        ge;

  assign rem_sh  = {rem_r[62:0], dvd_r[79]};
  assign ge      = rem_r[63] | (rem_sh >= dvs_r);
  assign rem_nxt = ge ? rem_sh - dvs_r : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        neg_r  <= neg;
        rem_r  <= '0;
        q_r    <= '0;
        sat_r  <= 1'b0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        dvd_r <= {dvd_r[78:0], 1'b0};
        rem_r <= rem_nxt;
        q_r   <= {q_r[48:0], ge};
        sat_r <= sat_r | (|q_r[49:48]);
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;

  always_comb begin
    if (neg_r) begin
      result = (sat_r || q_r > 50'h0_8000_0000_0000) ? V48_MIN : -$signed(q_r[47:0]);
    end else begin
      result = (sat_r || q_r > 50'h0_7FFF_FFFF_FFFF) ? V48_MAX : $signed(q_r[47:0]);
    end
  end

endmodule

### design/scd_lane.sv
module scd_lane
  import scd_pkg::*;
#(
  parameter int unsigned CNT_W = 17
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  input  logic                load,
  input  logic signed [32:0]  raw,
  input  cfg_t                cfg,
  input  logic [CNT_W-1:0]    count,
  output logic signed [47:0]  min_o,
  output logic signed [47:0]  max_o,
  output logic signed [47:0]  mean_o,
  output logic                done_o
);

  logic signed [32:0] raw_r;
  logic signed [64:0] nprod_r, dprod_r;
  logic               nneg_r, nzero_r, dzero_r;
  logic signed [47:0] low_r, high_r;
  logic signed [63:0] sum_r;

  logic signed [65:0] ndiff, ddiff, nabs, dabs;
  logic [63:0]        nm, dm, smag;
  logic signed [48:0] idv;
  logic signed [47:0] ident, ps, div_res;
  logic signed [64:0] sum_ext;
  logic [79:0]        dvd;
  logic [63:0]        dvs;
  logic               dneg, dsign;

  assign ndiff = 66'(nprod_r) - 66'(cfg.num_offset);
  assign ddiff = 66'(cfg.den_const) - 66'(dprod_r);
  assign nabs  = ndiff[65] ? -ndiff : ndiff;
  assign dabs  = ddiff[65] ? -ddiff : ddiff;
  assign nm    = nabs[63:0];
  assign dm    = dabs[63:0];
  assign dneg  = ddiff[65];
  assign smag  = sum_r[63] ? 64'(-sum_r) : sum_r;

  always_comb begin
    if (cmd.mean_start) begin
      dvd   = {16'd0, smag};
      dvs   = 64'(count);
      dsign = sum_r[63];
    end else begin
      dvd   = {nm, 16'd0};
      dvs   = dm;
      dsign = ndiff[65] ^ dneg;
    end
  end

  scd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start | cmd.mean_start),
    .dividend (dvd),
    .divisor  (dvs),
    .neg      (dsign),
    .done     (done_o),
    .result   (div_res)
  );

  assign idv = {raw_r, 16'd0};

  always_comb begin
    if (idv > 49'(V48_MAX)) begin
      ident = V48_MAX;
    end else if (idv < 49'(V48_MIN)) begin
      ident = V48_MIN;
    end else begin
      ident = idv[47:0];
    end
    if (!cfg.scale_mode) begin
      ps = ident;
    end else if (dzero_r) begin
      ps = nzero_r ? 48'sd0 : (nneg_r ? V48_MIN : V48_MAX);
    end else begin
      ps = div_res;
    end
  end

  assign sum_ext = 65'(sum_r) + 65'(ps);

  always_ff @(posedge clk) begin
    if (load) begin
      raw_r <= raw;
    end
    if (cmd.mul_en) begin
      nprod_r <= raw_r * cfg.num_gain;
      dprod_r <= raw_r * cfg.den_gain;
    end
    if (cmd.div_start) begin
      nneg_r  <= ndiff[65];
      nzero_r <= (nm == 64'd0);
      dzero_r <= (dm == 64'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.out_load) begin
      low_r  <= V48_MAX;
      high_r <= V48_MIN;
      sum_r  <= '0;
    end else if (cmd.acc_en) begin
      if (ps < low_r) begin
        low_r <= ps;
      end
      if (ps > high_r) begin
        high_r <= ps;
      end
      if (sum_ext[64] != sum_ext[63]) begin
        sum_r <= sum_ext[64] ? V64_MIN : V64_MAX;
      end else begin
        sum_r <= sum_ext[63:0];
      end
    end
  end

  assign min_o  = low_r;
  assign max_o  = high_r;
  assign mean_o = (count == '0) ? 48'sd0 : div_res;

endmodule

### design/scd_ctrl.sv
module scd_ctrl
  import scd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  accept,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.idle = 1'b1;
        if (accept) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        if (stat.full) begin
          state_nxt = stat.last ? ST_MSTART : ST_IDLE;
        end else begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc_en = 1'b1;
        state_nxt  = stat.last ? ST_MSTART : ST_IDLE;
      end
      ST_MSTART: begin
        cmd.mean_start = 1'b1;
        state_nxt      = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (stat.div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### design/scaled_cell_diff_statistics.sv
// One request runs through the multiply and setup steps, then an 80-step
// restoring division of one quotient bit per cycle, run for the stock and tuned cells
// side by side in two divider units. For a request marked last, the same dividers
// then form the two means before the result is loaded. The input
// side takes the next request while a result still waits in the output register.
// Configuration writes are always accepted and must be made only while the block is idle.
module scaled_cell_diff_statistics
  import scd_pkg::*;
#(
  parameter int unsigned MAX_CELLS = MAX_CELLS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [31:0]         in_stock_cell,
  input  logic [31:0]         in_tuned_cell,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [47:0]  out_stock_min,
  output logic signed [47:0]  out_stock_max,
  output logic signed [47:0]  out_stock_mean,
  output logic signed [47:0]  out_tuned_min,
  output logic signed [47:0]  out_tuned_max,
  output logic signed [47:0]  out_tuned_mean,
  output logic [16:0]         out_changed_cells,
  output logic [16:0]         out_cell_total,
  output logic                out_any_changed,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [3:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int unsigned CNT_W = $clog2(MAX_CELLS + 1);

  cfg_t  cfg_r;
  cmd_t  cmd;
  stat_t stat;

  logic               accept, last_r, diff_r, out_valid_r;
  logic [CNT_W-1:0]   cnt_r, diffc_r;
  logic signed [32:0] raw_s, raw_t;
  logic               done_s, done_t;
  logic signed [47:0] s_min, s_max, s_mean, t_min, t_max, t_mean;
  logic [63:0]        cnt_ext, diffc_ext;

  assign cfg_ready = 1'b1;
  assign in_stall  = !cmd.idle;
  assign accept    = in_valid && cmd.idle;
  assign raw_s     = assemble(in_stock_cell, cfg_r);
  assign raw_t     = assemble(in_tuned_cell, cfg_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cell_bytes   <= 3'd1;
      cfg_r.big_endian   <= 1'b0;
      cfg_r.signed_cells <= 1'b0;
      cfg_r.scale_mode   <= 1'b0;
      cfg_r.num_gain     <= 32'sd65536;
      cfg_r.num_offset   <= 32'sd0;
      cfg_r.den_const    <= 32'sd65536;
      cfg_r.den_gain     <= 32'sd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CELL_BYTES:   cfg_r.cell_bytes   <= cfg_data[2:0];
        REG_BIG_ENDIAN:   cfg_r.big_endian   <= cfg_data[0];
        REG_SIGNED_CELLS: cfg_r.signed_cells <= cfg_data[0];
        REG_SCALE_MODE:   cfg_r.scale_mode   <= cfg_data[0];
        REG_NUM_GAIN:     cfg_r.num_gain     <= $signed(cfg_data);
        REG_NUM_OFFSET:   cfg_r.num_offset   <= $signed(cfg_data);
        REG_DEN_CONST:    cfg_r.den_const    <= $signed(cfg_data);
        REG_DEN_GAIN:     cfg_r.den_gain     <= $signed(cfg_data);
        default:          cfg_r <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_r <= in_last;
      diff_r <= (raw_s != raw_t);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.out_load) begin
      cnt_r   <= '0;
      diffc_r <= '0;
    end else if (cmd.acc_en) begin
      cnt_r   <= cnt_r + 1'b1;
      diffc_r <= diffc_r + CNT_W'(diff_r);
    end
  end

  assign stat.full     = (cnt_r >= CNT_W'(MAX_CELLS));
  assign stat.last     = last_r;
  assign stat.div_done = done_s & done_t;
  assign stat.out_busy = out_valid_r & out_stall;

  scd_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .stat   (stat),
    .cmd    (cmd)
  );

  scd_lane #(.CNT_W(CNT_W)) u_stock (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .load   (accept),
    .raw    (raw_s),
    .cfg    (cfg_r),
    .count  (cnt_r),
    .min_o  (s_min),
    .max_o  (s_max),
    .mean_o (s_mean),
    .done_o (done_s)
  );

  scd_lane #(.CNT_W(CNT_W)) u_tuned (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .load   (accept),
    .raw    (raw_t),
    .cfg    (cfg_r),
    .count  (cnt_r),
    .min_o  (t_min),
    .max_o  (t_max),
    .mean_o (t_mean),
    .done_o (done_t)
  );

  assign cnt_ext   = 64'(cnt_r);
  assign diffc_ext = 64'(diffc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_stock_min     <= s_min;
      out_stock_max     <= s_max;
      out_stock_mean    <= s_mean;
      out_tuned_min     <= t_min;
      out_tuned_max     <= t_max;
      out_tuned_mean    <= t_mean;
      out_changed_cells <= diffc_ext[16:0];
      out_cell_total    <= cnt_ext[16:0];
      out_any_changed   <= (diffc_r != '0);
    end
  end

  assign out_valid = out_valid_r;

  // Assertions.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_CELLS))
    else $error("cell count beyond its limit");

  a_diff_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    diffc_r <= cnt_r)
    else $error("changed count exceeds cell count");

  a_clear_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (cnt_r == '0) && (diffc_r == '0) && out_valid_r)
    else $error("statistics not cleared after result load");

  a_no_load_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

endmodule

### dv/tb_scaled_cell_diff_statistics.sv
module tb_scaled_cell_diff_statistics
  import scd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int RANDOM_ITEMS   = 1425;

  typedef struct {
    logic [47:0] stock_min;
    logic [47:0] stock_max;
    logic [47:0] stock_mean;
    logic [47:0] tuned_min;
    logic [47:0] tuned_max;
    logic [47:0] tuned_mean;
    logic [16:0] changed;
    logic [16:0] total;
    logic        any;
  } map_stats_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] in_stock_cell = '0;
  logic [31:0] in_tuned_cell = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [47:0] out_stock_min, out_stock_max, out_stock_mean;
  logic signed [47:0] out_tuned_min, out_tuned_max, out_tuned_mean;
  logic [16:0] out_changed_cells, out_cell_total;
  logic out_any_changed;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  scaled_cell_diff_statistics u_dut (.*);

  always #5 clk = ~clk;

  cfg_t        shadow_cfg;
  longint      stock_lo, stock_hi, tuned_lo, tuned_hi, stock_acc, tuned_acc;
  int unsigned cells_seen, cells_changed;
  map_stats_t  pending_stats[$];
  int          errors = 0;
  int          send_gap = 0;
  bit          burst = 1'b0;
  int          stall_left = 0;
  int          quiet_cycles = 0;
  int          items_sent = 0;

  function automatic longint clamp48(longint v);
    if (v > longint'(V48_MAX)) return longint'(V48_MAX);
    if (v < longint'(V48_MIN)) return longint'(V48_MIN);
    return v;
  endfunction

  function automatic longint cell_value(logic [31:0] x);
    int          n;
    logic [31:0] v;
    n = (shadow_cfg.cell_bytes == 0) ? 1 : (shadow_cfg.cell_bytes > 4 ? 4 : shadow_cfg.cell_bytes);
    v = '0;
    if (shadow_cfg.big_endian) begin
      for (int i = 0; i < n; i++) v = (v << BYTE_W) | x[i*BYTE_W +: BYTE_W];
    end else begin
      for (int i = 0; i < n * BYTE_W; i++) v[i] = x[i];
    end
    if (shadow_cfg.signed_cells && v[n*BYTE_W-1])
      return longint'({32'd0, v}) - (longint'(1) << (n * BYTE_W));
    return longint'({32'd0, v});
  endfunction

  function automatic longint scaled_value(longint raw);
    longint      p, r;
    logic [63:0] nm, dm, rem;
    logic [49:0] q;
    logic        nneg, dneg, top, sat;
    if (!shadow_cfg.scale_mode) return clamp48(raw * 65536);
    p = raw * longint'(shadow_cfg.num_gain);
    r = longint'(shadow_cfg.num_offset);
    nneg = p < r;
    nm = nneg ? r - p : p - r;
    p = longint'(shadow_cfg.den_const);
    r = raw * longint'(shadow_cfg.den_gain);
    dneg = p < r;
    dm = dneg ? r - p : p - r;
    if (dm == 0) begin
      if (nm == 0) return 0;
      return nneg ? longint'(V48_MIN) : longint'(V48_MAX);
    end
    rem = '0;
    q = '0;
    sat = 1'b0;
    for (int i = DIV_STEPS - 1; i >= 0; i--) begin
      top = rem[63];
      rem = {rem[62:0], (i >= 16) ? nm[i-16] : 1'b0};
      if (q[49:48] != 0) sat = 1'b1;
      q = {q[48:0], 1'b0};
      if (top || rem >= dm) begin
        rem = rem - dm;
        q[0] = 1'b1;
      end
    end
    if (nneg != dneg) begin
      if (sat || q > 50'h8000_0000_0000) return longint'(V48_MIN);
      return -longint'({14'd0, q});
    end
    if (sat || q > 50'h7FFF_FFFF_FFFF) return longint'(V48_MAX);
    return longint'({14'd0, q});
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    if (b > 0 && a > longint'(V64_MAX) - b) return longint'(V64_MAX);
    if (b < 0 && a < longint'(V64_MIN) - b) return longint'(V64_MIN);
    return a + b;
  endfunction

  function automatic void clear_map();
    stock_lo = V48_MAX;
    tuned_lo = V48_MAX;
    stock_hi = V48_MIN;
    tuned_hi = V48_MIN;
    stock_acc = 0;
    tuned_acc = 0;
    cells_seen = 0;
    cells_changed = 0;
  endfunction

  function automatic void accumulate_cell(logic [31:0] s, logic [31:0] t, logic last);
    longint     rs, rt, ps, pt;
    map_stats_t e;
    if (cells_seen < MAX_CELLS_DEF) begin
      rs = cell_value(s);
      rt = cell_value(t);
      ps = scaled_value(rs);
      pt = scaled_value(rt);
      if (ps < stock_lo) stock_lo = ps;
      if (ps > stock_hi) stock_hi = ps;
      if (pt < tuned_lo) tuned_lo = pt;
      if (pt > tuned_hi) tuned_hi = pt;
      stock_acc = sat_sum(stock_acc, ps);
      tuned_acc = sat_sum(tuned_acc, pt);
      if (rs != rt) cells_changed++;
      cells_seen++;
    end
    if (!last) return;
    e.stock_min = stock_lo[47:0];
    e.stock_max = stock_hi[47:0];
    e.tuned_min = tuned_lo[47:0];
    e.tuned_max = tuned_hi[47:0];
    e.stock_mean = (cells_seen == 0) ? '0 : clamp48(stock_acc / longint'(cells_seen));
    e.tuned_mean = (cells_seen == 0) ? '0 : clamp48(tuned_acc / longint'(cells_seen));
    e.changed = cells_changed[16:0];
    e.total = cells_seen[16:0];
    e.any = cells_changed != 0;
    pending_stats.push_back(e);
    clear_map();
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("Mismatch on %s: got %h, expected %h", field, got, want);
    errors++;
  endtask

  task automatic send_cell(logic [31:0] s, logic [31:0] t, logic last);
    repeat (send_gap) @(posedge clk);
    in_valid <= 1'b1;
    in_stock_cell <= s;
    in_tuned_cell <= t;
    in_last <= last;
    do @(posedge clk); while (in_stall);
    accumulate_cell(s, t, last);
    items_sent++;
    send_gap = burst ? 0 : $urandom_range(0, 11);
    if (send_gap != 0) in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    send_gap = 0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CELL_BYTES:   shadow_cfg.cell_bytes = data[2:0];
      REG_BIG_ENDIAN:   shadow_cfg.big_endian = data[0];
      REG_SIGNED_CELLS: shadow_cfg.signed_cells = data[0];
      REG_SCALE_MODE:   shadow_cfg.scale_mode = data[0];
      REG_NUM_GAIN:     shadow_cfg.num_gain = data;
      REG_NUM_OFFSET:   shadow_cfg.num_offset = data;
      REG_DEN_CONST:    shadow_cfg.den_const = data;
      REG_DEN_GAIN:     shadow_cfg.den_gain = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_coefs(logic [31:0] f, logic [31:0] c, logic [31:0] b, logic [31:0] e);
    write_reg(REG_NUM_GAIN, f);
    write_reg(REG_NUM_OFFSET, c);
    write_reg(REG_DEN_CONST, b);
    write_reg(REG_DEN_GAIN, e);
  endtask

  function automatic logic [31:0] pick_coef();
    logic [31:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom_range(0, 32'h3_FFFF);
      2: v = -$urandom_range(0, 32'h3_FFFF);
      3: v = '0;
      default: v = 32'h1_0000;
    endcase
    return v;
  endfunction

  task automatic test_reset_config();
    send_cell(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_cell(32'hFFFF_FFFF, 32'h1234_56FF, 1'b0);
    send_cell(32'h0000_0080, 32'h0000_0081, 1'b1);
    wait_idle();
  endtask

  task automatic test_cell_formats();
    for (int n = 0; n < 8; n++) begin
      write_reg(REG_CELL_BYTES, n);
      write_reg(REG_BIG_ENDIAN, n & 1);
      write_reg(REG_SIGNED_CELLS, (n >> 1) & 1);
      send_cell(32'h8000_0080, 32'hFFFF_FFFF, 1'b0);
      send_cell(32'h7F01_807F, 32'h0000_0000, 1'b1);
      wait_idle();
    end
  endtask

  task automatic test_scaling_extremes();
    write_reg(REG_CELL_BYTES, 4);
    write_reg(REG_BIG_ENDIAN, 0);
    write_reg(REG_SIGNED_CELLS, 1);
    write_reg(REG_SCALE_MODE, 1);
    write_coefs(32'h1_0000, 32'h0, 32'h0, 32'h0);
    send_cell(32'h0, 32'h5, 1'b0);
    send_cell(32'hFFFF_FFF0, 32'h0, 1'b1);
    wait_idle();
    write_coefs(32'h7FFF_FFFF, 32'h8000_0000, 32'h1_0000, 32'h0);
    send_cell(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_cell(32'hFFFF_FFFF, 32'h1, 1'b1);
    wait_idle();
    write_reg(REG_SIGNED_CELLS, 0);
    write_coefs(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_cell(32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
    send_cell(32'h3, 32'h0, 1'b1);
    wait_idle();
    write_reg(REG_SCALE_MODE, 0);
    send_cell(32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_maps();
    int          len;
    logic [31:0] s, t;
    bit          paused;
    paused = 1'b0;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        wait_idle();
        write_reg(REG_CELL_BYTES, $urandom_range(0, 7));
        write_reg(REG_BIG_ENDIAN, $urandom_range(0, 1));
        write_reg(REG_SIGNED_CELLS, $urandom_range(0, 1));
        write_reg(REG_SCALE_MODE, $urandom_range(0, 3) != 0);
        write_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef());
        if ($urandom_range(0, 9) == 0) write_reg($urandom_range(8, 15), $urandom);
      end
      burst = $urandom_range(0, 3) == 0;
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        s = $urandom;
        case ($urandom_range(0, 3))
          0: t = $urandom;
          1: t = s ^ (32'h1 << $urandom_range(0, 31));
          default: t = s;
        endcase
        send_cell(s, t, i == len - 1);
        if (!paused && items_sent > RANDOM_ITEMS / 2 && i == 0 && len > 1) begin
          paused = 1'b1;
          while (pending_stats.size() != 0) @(posedge clk);
        end
      end
    end
    burst = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      stall_left = burst ? 0 : $urandom_range(0, 11);
      out_stall <= stall_left != 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= stall_left != 0;
    end
  end

  always @(posedge clk) begin
    map_stats_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_stats.size() == 0) begin
        $display("Result with no expected map statistics");
        errors++;
      end else begin
        e = pending_stats.pop_front();
        if (out_stock_min !== e.stock_min) report_mismatch("stock_min", out_stock_min, e.stock_min);
        if (out_stock_max !== e.stock_max) report_mismatch("stock_max", out_stock_max, e.stock_max);
        if (out_stock_mean !== e.stock_mean)
          report_mismatch("stock_mean", out_stock_mean, e.stock_mean);
        if (out_tuned_min !== e.tuned_min) report_mismatch("tuned_min", out_tuned_min, e.tuned_min);
        if (out_tuned_max !== e.tuned_max) report_mismatch("tuned_max", out_tuned_max, e.tuned_max);
        if (out_tuned_mean !== e.tuned_mean)
          report_mismatch("tuned_mean", out_tuned_mean, e.tuned_mean);
        if (out_changed_cells !== e.changed)
          report_mismatch("changed_cells", out_changed_cells, e.changed);
        if (out_cell_total !== e.total) report_mismatch("cell_total", out_cell_total, e.total);
        if (out_any_changed !== e.any) report_mismatch("any_changed", out_any_changed, e.any);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready) || !rst_n)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    shadow_cfg = '{cell_bytes: 3'd1, big_endian: 1'b0, signed_cells: 1'b0, scale_mode: 1'b0,
                   num_gain: 32'sh1_0000, num_offset: 32'sh0, den_const: 32'sh1_0000,
                   den_gain: 32'sh0};
    clear_map();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_config();
    test_cell_formats();
    test_scaling_extremes();
    test_random_maps();
    wait_idle();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
